### rtl/lockin_quadrature_demodulator_defines.svh
// assertion macros for the lock-in demodulator checker
// no dependencies; included by the checker file only
`ifndef LOCKIN_QUADRATURE_DEMODULATOR_DEFINES_SVH
`define LOCKIN_QUADRATURE_DEMODULATOR_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define LQD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define LQD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define LQD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lqd_pkg.sv
// shared constants, record type and quarter-wave sine table
// no dependencies
package lqd_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int MAX_RECORD       = 1048576;

    localparam int PHASE_W      = 32;
    localparam int PHASE_FRAC_W = 30;
    localparam int ROM_Q        = (SINE_TABLE_DEPTH >= 8) ? SINE_TABLE_DEPTH / 4 : 2;
    localparam int ROM_IDX_W    = $clog2(ROM_Q + 1);
    localparam int ROM_W        = 16;
    localparam int PROD_W       = SAMPLE_WIDTH + ROM_W;
    localparam int COUNT_W      = $clog2(MAX_RECORD + 1);
    localparam int SCALE_W      = 16;
    localparam int SUM_W        = 52;
    localparam int HALF_W       = SUM_W / 2;
    localparam int K_W          = SCALE_W + 1;
    localparam int PK_W         = SUM_W + K_W;
    localparam int DIV_CNT_W    = $clog2(PK_W);
    localparam int ROUND_SH     = 23;
    localparam int MAG_W        = PK_W - ROUND_SH + 1;
    localparam int OUT_W        = 26;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_OFFSET = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_SCALE = 2'd2;
    localparam logic [SCALE_W-1:0]    SCALE_RESET      = 16'd256;

    // one finished record handed from the front end to the back end
    typedef struct packed {
        logic signed [SUM_W-1:0] sin_sum;
        logic signed [SUM_W-1:0] cos_sum;
        logic [COUNT_W-1:0]      count;
        logic [SCALE_W-1:0]      scale;
    } record_t;

    typedef logic [ROM_W-2:0] rom_tab_t [ROM_Q+1];

    // round(32767*sin(pi*k/(2Q))) via a Q2.30 Horner series up to x^11
    function automatic logic [ROM_W-2:0] rom_entry(longint unsigned k);
        longint unsigned one_q30;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned d;
        longint unsigned s;
        longint unsigned v;
        one_q30 = 64'd1073741824;
        x  = (64'd1686629713 * k + longint'(ROM_Q / 2)) / ROM_Q;
        x2 = (x * x) >> 30;
        t  = one_q30;
        d  = ((x2 * t) >> 30) / 110;
        t  = (d >= one_q30) ? 64'd0 : one_q30 - d;
        d  = ((x2 * t) >> 30) / 72;
        t  = (d >= one_q30) ? 64'd0 : one_q30 - d;
        d  = ((x2 * t) >> 30) / 42;
        t  = (d >= one_q30) ? 64'd0 : one_q30 - d;
        d  = ((x2 * t) >> 30) / 20;
        t  = (d >= one_q30) ? 64'd0 : one_q30 - d;
        d  = ((x2 * t) >> 30) / 6;
        t  = (d >= one_q30) ? 64'd0 : one_q30 - d;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (one_q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[ROM_W-2:0];
    endfunction

    function automatic rom_tab_t build_rom();
        rom_tab_t r;
        for (int k = 0; k <= ROM_Q; k++) begin
            r[k] = rom_entry(longint'(k));
        end
        return r;
    endfunction

    localparam rom_tab_t SINE_ROM = build_rom();

endpackage

### rtl/lqd_front.sv
// front end: sample intake, phase generation, sine lookup, multiply and accumulate
// depends on lqd_pkg
module lqd_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lqd_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                  s_last,
    input  logic [lqd_pkg::PHASE_W-1:0]           phase_step,
    input  logic [lqd_pkg::PHASE_W-1:0]           phase_offset,
    input  logic [lqd_pkg::SCALE_W-1:0]           sample_scale,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output lqd_pkg::record_t                      push_rec
);
    import lqd_pkg::*;

    localparam int JPROD_W = PHASE_FRAC_W + ROM_IDX_W;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic                           v1_reg, v2_reg, v3_reg, v4_reg;
    logic [PHASE_W-1:0]             p1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_reg, x2_reg, x3_reg;
    logic                           end1_reg, end2_reg, end3_reg, end4_reg;
    logic [COUNT_W-1:0]             n1_reg, n2_reg, n3_reg, n4_reg;
    logic [ROM_IDX_W-1:0]           addr_s_reg, addr_c_reg;
    logic                           neg_s_reg, neg_c_reg;
    logic signed [ROM_W-1:0]        val_s_reg, val_c_reg;
    logic signed [PROD_W-1:0]       prod_s_reg, prod_c_reg;
    logic signed [SUM_W-1:0]        sin_sum_reg, sin_sum_next;
    logic signed [SUM_W-1:0]        cos_sum_reg, cos_sum_next;

    logic                 adv;
    logic                 accept;
    logic [PHASE_W-1:0]   p_cur;
    logic [COUNT_W-1:0]   n_inc;
    logic                 rec_end;
    logic [JPROD_W-1:0]   jprod;
    logic [ROM_IDX_W-1:0] j_idx;
    logic [ROM_IDX_W-1:0] j_mirror;
    logic signed [ROM_W-1:0] rom_s, rom_c;
    logic signed [SUM_W-1:0] sin_acc, cos_acc;

    // the whole pipe holds while a finished record waits for queue space
    assign adv     = !(v4_reg && end4_reg && !push_ready);
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    assign p_cur   = (count_reg == '0) ? phase_offset : phase_reg;
    assign n_inc   = count_reg + COUNT_W'(1);
    assign rec_end = s_last || (n_inc == COUNT_W'(MAX_RECORD));

    always_comb begin
        count_next = count_reg;
        phase_next = phase_reg;
        if (accept) begin
            count_next = rec_end ? '0 : n_inc;
            phase_next = rec_end ? '0 : p_cur + phase_step;
        end
    end

    // table index within the quarter wave; cosine shares it with the quadrant moved by one
    assign jprod    = JPROD_W'(p1_reg[PHASE_FRAC_W-1:0]) * JPROD_W'(ROM_Q);
    assign j_idx    = jprod[JPROD_W-1:PHASE_FRAC_W];
    assign j_mirror = ROM_IDX_W'(ROM_Q) - j_idx;

    assign rom_s = neg_s_reg ? -$signed({1'b0, SINE_ROM[addr_s_reg]})
                             :  $signed({1'b0, SINE_ROM[addr_s_reg]});
    assign rom_c = neg_c_reg ? -$signed({1'b0, SINE_ROM[addr_c_reg]})
                             :  $signed({1'b0, SINE_ROM[addr_c_reg]});

    assign sin_acc = sin_sum_reg + SUM_W'(prod_s_reg);
    assign cos_acc = cos_sum_reg + SUM_W'(prod_c_reg);

    always_comb begin
        sin_sum_next = sin_sum_reg;
        cos_sum_next = cos_sum_reg;
        if (adv && v4_reg) begin
            sin_sum_next = end4_reg ? '0 : sin_acc;
            cos_sum_next = end4_reg ? '0 : cos_acc;
        end
    end

    assign push_valid       = v4_reg && end4_reg;
    assign push_rec.sin_sum = sin_acc;
    assign push_rec.cos_sum = cos_acc;
    assign push_rec.count   = n4_reg;
    assign push_rec.scale   = sample_scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            phase_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            sin_sum_reg <= '0;
            cos_sum_reg <= '0;
        end else begin
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            sin_sum_reg <= sin_sum_next;
            cos_sum_reg <= cos_sum_next;
            if (adv) begin
                v1_reg <= accept;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg     <= p_cur;
            x1_reg     <= s_sample;
            end1_reg   <= rec_end;
            n1_reg     <= n_inc;

            addr_s_reg <= p1_reg[PHASE_FRAC_W] ? j_mirror : j_idx;
            addr_c_reg <= p1_reg[PHASE_FRAC_W] ? j_idx : j_mirror;
            neg_s_reg  <= p1_reg[PHASE_W-1];
            neg_c_reg  <= p1_reg[PHASE_W-1] ^ p1_reg[PHASE_FRAC_W];
            x2_reg     <= x1_reg;
            end2_reg   <= end1_reg;
            n2_reg     <= n1_reg;

            val_s_reg  <= rom_s;
            val_c_reg  <= rom_c;
            x3_reg     <= x2_reg;
            end3_reg   <= end2_reg;
            n3_reg     <= n2_reg;

            prod_s_reg <= x3_reg * val_s_reg;
            prod_c_reg <= x3_reg * val_c_reg;
            end4_reg   <= end3_reg;
            n4_reg     <= n3_reg;
        end
    end

endmodule

### rtl/lqd_queue.sv
// short queue of finished records between front end and back end
// depends on lqd_pkg
module lqd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  lqd_pkg::record_t push_rec,
    output logic             pop_valid,
    input  logic             pop_ready,
    output lqd_pkg::record_t pop_rec
);
    import lqd_pkg::*;

    record_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

### rtl/lqd_back.sv
// back end: per-record scaling 2*sum*scale/N with a shared multiplier and serial divider
// depends on lqd_pkg
module lqd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  lqd_pkg::record_t                  pop_rec,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lqd_pkg::OUT_W-1:0]  m_in_phase,
    output logic signed [lqd_pkg::OUT_W-1:0]  m_quadrature,
    output logic [lqd_pkg::COUNT_W-1:0]       m_count
);
    import lqd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ABS    = 3'd1;
    localparam logic [2:0] ST_MUL_LO = 3'd2;
    localparam logic [2:0] ST_MUL_HI = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_ROUND  = 3'd5;
    localparam logic [2:0] ST_HOLD   = 3'd6;

    logic [2:0]               state_reg, state_next;
    record_t                  rec_reg;
    logic [K_W-1:0]           k_reg;
    logic                     branch_reg;
    logic                     neg_reg;
    logic [SUM_W-1:0]         mag_reg;
    logic [PK_W-1:0]          acc_reg;
    logic [COUNT_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic signed [OUT_W-1:0]  res_s_reg;
    logic signed [OUT_W-1:0]  res_c_reg;
    logic                     m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]  m_in_phase_reg;
    logic signed [OUT_W-1:0]  m_quadrature_reg;
    logic [COUNT_W-1:0]       m_count_reg;

    logic signed [SUM_W-1:0]  sel_sum;
    logic [HALF_W-1:0]        mul_half;
    logic [HALF_W+K_W-1:0]    pprod;
    logic [COUNT_W:0]         rem_sh;
    logic                     q_bit;
    logic [PK_W:0]            rnd;
    logic [MAG_W-1:0]         mag_q;
    logic [MAG_W-1:0]         mag_lim;
    logic [MAG_W-1:0]         mag_sat;
    logic signed [OUT_W-1:0]  res_val;
    logic                     out_load;

    assign pop_ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    assign sel_sum  = branch_reg ? rec_reg.cos_sum : rec_reg.sin_sum;
    assign mul_half = (state_reg == ST_MUL_LO) ? mag_reg[HALF_W-1:0]
                                               : mag_reg[SUM_W-1 -: HALF_W];
    assign pprod    = mul_half * k_reg;

    // restoring division step: shift in the next dividend bit, quotient bit shifts in below
    assign rem_sh = {rem_reg, acc_reg[PK_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, rec_reg.count});

    // round half up on the magnitude, then clamp to the signed output range
    assign rnd     = {1'b0, acc_reg} + ((PK_W + 1)'(1) << (ROUND_SH - 1));
    assign mag_q   = rnd[PK_W:ROUND_SH];
    assign mag_lim = neg_reg ? (MAG_W'(1) << (OUT_W - 1))
                             : (MAG_W'(1) << (OUT_W - 1)) - MAG_W'(1);
    assign mag_sat = (mag_q > mag_lim) ? mag_lim : mag_q;
    assign res_val = neg_reg ? -$signed(mag_sat[OUT_W-1:0]) : $signed(mag_sat[OUT_W-1:0]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (pop_valid) state_next = ST_ABS;
            ST_ABS:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == DIV_CNT_W'(PK_W - 1)) state_next = ST_ROUND;
            ST_ROUND:  state_next = branch_reg ? ST_HOLD : ST_ABS;
            ST_HOLD:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            branch_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_IDLE) begin
                branch_reg <= 1'b0;
            end else if (state_reg == ST_ROUND) begin
                branch_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                rec_reg <= pop_rec;
                k_reg   <= {pop_rec.scale, 1'b0};
            end
            ST_ABS: begin
                neg_reg <= sel_sum[SUM_W-1];
                mag_reg <= sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
            end
            ST_MUL_LO: begin
                acc_reg <= PK_W'(pprod);
            end
            ST_MUL_HI: begin
                acc_reg <= acc_reg + (PK_W'(pprod) << HALF_W);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg <= q_bit ? COUNT_W'(rem_sh - {1'b0, rec_reg.count})
                                 : rem_sh[COUNT_W-1:0];
                acc_reg <= {acc_reg[PK_W-2:0], q_bit};
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            ST_ROUND: begin
                if (branch_reg) begin
                    res_c_reg <= res_val;
                end else begin
                    res_s_reg <= res_val;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    m_in_phase_reg   <= res_s_reg;
                    m_quadrature_reg <= res_c_reg;
                    m_count_reg      <= rec_reg.count;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_in_phase   = m_in_phase_reg;
    assign m_quadrature = m_quadrature_reg;
    assign m_count      = m_count_reg;

endmodule

### rtl/lockin_quadrature_demodulator.sv
// lock-in quadrature demodulator top level: config registers, front end, record queue, back end
// path from last sample of a record to result: 4-stage front pipe, queue,
//   then per branch abs, two partial products, a 69-step serial divide and rounding
// throughput: one sample per cycle, held while a finished record waits for queue space
// reset: synchronous active-low aresetn clears pipe, sums, queue and output; scale resets to 256
module lockin_quadrature_demodulator (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [lqd_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                    s_last,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [lqd_pkg::OUT_W-1:0]        m_in_phase,
    output logic signed [lqd_pkg::OUT_W-1:0]        m_quadrature,
    output logic [lqd_pkg::COUNT_W-1:0]             m_count,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lqd_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [lqd_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import lqd_pkg::*;

    logic [PHASE_W-1:0] phase_step_reg;
    logic [PHASE_W-1:0] phase_offset_reg;
    logic [SCALE_W-1:0] sample_scale_reg;

    logic    push_valid, push_ready;
    record_t push_rec;
    logic    pop_valid, pop_ready;
    record_t pop_rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= '0;
            phase_offset_reg <= '0;
            sample_scale_reg <= SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[PHASE_W-1:0];
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[PHASE_W-1:0];
                REG_SAMPLE_SCALE: sample_scale_reg <= cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lqd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last       (s_last),
        .phase_step   (phase_step_reg),
        .phase_offset (phase_offset_reg),
        .sample_scale (sample_scale_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_rec     (push_rec)
    );

    lqd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    lqd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_rec      (pop_rec),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_in_phase   (m_in_phase),
        .m_quadrature (m_quadrature),
        .m_count      (m_count)
    );

endmodule

### rtl/lqd_checker.sv
// port-level checks for the lock-in demodulator, bound to the top level
// depends on lqd_pkg and lockin_quadrature_demodulator_defines.svh
`include "lockin_quadrature_demodulator_defines.svh"

module lqd_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [lqd_pkg::OUT_W-1:0]        m_in_phase,
    input logic signed [lqd_pkg::OUT_W-1:0]        m_quadrature,
    input logic [lqd_pkg::COUNT_W-1:0]             m_count
);
    import lqd_pkg::*;

    // reset empties the output and opens the sample input
    `LQD_ASSERT_ALWAYS_NEXT(a_reset_state, aclk, !aresetn, !m_valid && s_ready, "reset state wrong")

    // a stalled result keeps its values
    `LQD_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_in_phase) && $stable(m_quadrature) && $stable(m_count), "stalled result changed")

    // a record holds at least one and at most the maximum number of samples
    `LQD_ASSERT_IMP(a_count_range, aclk, aresetn, m_valid, m_count != '0 && m_count <= COUNT_W'(MAX_RECORD), "record count out of range")

endmodule

bind lockin_quadrature_demodulator lqd_checker u_lqd_checker (.*);

### tb/tb.sv
// self-checking testbench for lockin_quadrature_demodulator: directed and random records
// depends on rtl/lqd_pkg.sv and rtl/lockin_quadrature_demodulator.sv
`timescale 1ns / 100ps

module tb;
    import lqd_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int SAMPLE_MAX   = 2 ** (SAMPLE_WIDTH - 1) - 1;
    localparam int SAMPLE_MIN   = -(2 ** (SAMPLE_WIDTH - 1));
    localparam int DRAIN_CYCLES = 200;
    localparam int ITEM_TARGET  = 800;

    typedef struct packed {
        logic signed [OUT_W-1:0] in_phase;
        logic signed [OUT_W-1:0] quadrature;
        logic [COUNT_W-1:0]      count;
    } demod_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_sample;
    logic                           s_last;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [OUT_W-1:0]        m_in_phase;
    logic signed [OUT_W-1:0]        m_quadrature;
    logic [COUNT_W-1:0]             m_count;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_ADDR_W-1:0]          cfg_addr;
    logic [CFG_DATA_W-1:0]          cfg_data;

    // predictor state
    int              sin_quarter [0:ROM_Q];
    logic [31:0]     step_word;
    logic [31:0]     start_phase;
    logic [31:0]     nco_phase;
    logic [15:0]     gain_q88;
    int              samples_in_record;
    longint          i_accum;
    longint          q_accum;
    demod_result_t   pending_results [$];

    int mismatches;
    bit sample_gaps;
    bit result_stalls;

    lockin_quadrature_demodulator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_in_phase   (m_in_phase),
        .m_quadrature (m_quadrature),
        .m_count      (m_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // quarter-wave entry k: Q2.30 Horner series of sin up to x^11
    function automatic int quarter_sine_entry(longint unsigned k);
        longint unsigned one_q30;
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint unsigned step_down;
        longint unsigned prod;
        longint unsigned amp;
        int unsigned     horner_div [5];
        one_q30    = 64'd1 << 30;
        horner_div = '{110, 72, 42, 20, 6};
        angle      = (64'd1686629713 * k + ROM_Q / 2) / ROM_Q;
        angle_sq   = (angle * angle) >> 30;
        term       = one_q30;
        foreach (horner_div[i]) begin
            step_down = ((angle_sq * term) >> 30) / horner_div[i];
            term      = (step_down >= one_q30) ? 64'd0 : one_q30 - step_down;
        end
        prod = (angle * term) >> 30;
        amp  = (prod * 64'd32767 + (one_q30 >> 1)) >> 30;
        if (amp > 64'd32767) begin
            amp = 64'd32767;
        end
        return int'(amp);
    endfunction

    function automatic int sine_lookup(logic [31:0] ph);
        longint unsigned frac;
        longint unsigned j;
        int              v;
        frac = ph[29:0];
        j    = (frac * ROM_Q) >> 30;
        if (j > ROM_Q) begin
            j = ROM_Q;
        end
        v = ph[30] ? sin_quarter[ROM_Q - j] : sin_quarter[j];
        return ph[31] ? -v : v;
    endfunction

    // 2*accum*gain/(n*2^23), rounded half away from zero, then saturated
    function automatic logic signed [OUT_W-1:0] normalize_branch(longint accum, int unsigned n,
                                                                 logic [15:0] gain);
        longint unsigned mag;
        longint unsigned k2;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned scaled;
        logic [63:0]     wrapped;
        bit              negative;
        negative = accum < 0;
        mag      = negative ? -accum : accum;
        k2       = gain;
        k2       = k2 << 1;
        quo      = mag / n;
        rem      = mag % n;
        scaled   = quo * k2 + (rem * k2) / n;
        mag      = (scaled + (64'd1 << 22)) >> 23;
        if (negative) begin
            if (mag > (64'd1 << (OUT_W - 1))) begin
                mag = 64'd1 << (OUT_W - 1);
            end
            wrapped = 64'd0 - mag;
        end else begin
            if (mag > (64'd1 << (OUT_W - 1)) - 1) begin
                mag = (64'd1 << (OUT_W - 1)) - 1;
            end
            wrapped = mag;
        end
        return wrapped[OUT_W-1:0];
    endfunction

    function automatic void demodulate_sample(logic signed [SAMPLE_WIDTH-1:0] smp,
                                              logic last_flag);
        logic [31:0]   ph;
        longint        x;
        demod_result_t r;
        ph = (samples_in_record == 0) ? start_phase : nco_phase;
        x  = smp;
        i_accum += x * sine_lookup(ph);
        q_accum += x * sine_lookup(ph + 32'h4000_0000);
        nco_phase = ph + step_word;
        samples_in_record++;
        // a record that reaches the maximum length closes on its own
        if (last_flag || samples_in_record >= MAX_RECORD) begin
            r.in_phase   = normalize_branch(i_accum, samples_in_record, gain_q88);
            r.quadrature = normalize_branch(q_accum, samples_in_record, gain_q88);
            r.count      = COUNT_W'(samples_in_record);
            pending_results = {pending_results, r};
            nco_phase         = '0;
            samples_in_record = 0;
            i_accum           = 0;
            q_accum           = 0;
        end
    endfunction

    function automatic int random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return int'($urandom_range(0, 2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
        endcase
    endfunction

    task automatic push_sample(input int value, input logic last_flag);
        logic signed [SAMPLE_WIDTH-1:0] smp;
        smp = SAMPLE_WIDTH'(value);
        if (sample_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= last_flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        demodulate_sample(smp, last_flag);
    endtask

    task automatic send_record(input int vals [$]);
        foreach (vals[i]) begin
            push_sample(vals[i], i == vals.size() - 1);
        end
    endtask

    task automatic offer_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (addr)
            REG_PHASE_STEP:   step_word   = data;
            REG_PHASE_OFFSET: start_phase = data;
            REG_SAMPLE_SCALE: gain_q88    = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // valid stays up across the writes and drops once after the last one
    task automatic program_registers(input logic [31:0] stp, input logic [31:0] ofs,
                                     input logic [15:0] scl, input bit poke_unused);
        offer_register(REG_PHASE_STEP, stp);
        offer_register(REG_PHASE_OFFSET, ofs);
        offer_register(REG_SAMPLE_SCALE, {16'($urandom_range(0, 16'hFFFF)), scl});
        if (poke_unused) begin
            offer_register(REG_UNUSED, $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    // drop the sample request, let every pending record come back, then let the divider settle
    task automatic wait_idle();
        int guard;
        s_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 400000) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            if (mismatches <= 10) begin
                $display("%0d expected results never arrived", pending_results.size());
            end
            pending_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_settings();
        int rec [$];
        rec = {SAMPLE_MAX};
        send_record(rec);
        rec = {SAMPLE_MIN};
        send_record(rec);
        rec = {0, -1, 1};
        send_record(rec);
    endtask

    task automatic test_register_extremes();
        int rec [$];
        wait_idle();
        program_registers(32'h4000_0000, 32'hC000_0000, 16'hFFFF, 1'b1);
        rec = {SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
        send_record(rec);
        rec = {SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
        send_record(rec);
        wait_idle();
        program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        rec = {SAMPLE_MAX, SAMPLE_MIN};
        send_record(rec);
        // smallest nonzero gain: results land near the rounding boundary
        wait_idle();
        program_registers(32'h0000_0000, 32'h4000_0000, 16'h0001, 1'b1);
        rec = {128};
        send_record(rec);
        rec = {-128};
        send_record(rec);
        rec = {64};
        send_record(rec);
        wait_idle();
        program_registers(32'h1234_5678, 32'h8000_0000, SCALE_RESET, 1'b0);
        rec = {};
        repeat (6) rec = {rec, random_sample()};
        send_record(rec);
    endtask

    task automatic test_random_records();
        int          rec [$];
        int          items;
        int          records;
        int          len;
        logic [31:0] stp;
        logic [31:0] ofs;
        logic [15:0] scl;
        items   = 0;
        records = 0;
        while (items < ITEM_TARGET || records < 48) begin
            wait_idle();
            stp = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF :
                  ($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0400_0000));
            ofs = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
            case ($urandom_range(0, 5))
                0: scl = 16'h0000;
                1: scl = 16'hFFFF;
                2: scl = SCALE_RESET;
                default: scl = 16'($urandom_range(0, 16'hFFFF));
            endcase
            program_registers(stp, ofs, scl, $urandom_range(0, 3) == 0);
            if (items >= ITEM_TARGET * 4 / 5) begin
                sample_gaps   = 1'b0;
                result_stalls = 1'b0;
            end else begin
                sample_gaps   = $urandom_range(0, 3) != 0;
                result_stalls = $urandom_range(0, 3) != 0;
            end
            repeat ($urandom_range(3, 8)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) :
                      $urandom_range(1, 16);
                rec = {};
                repeat (len) rec = {rec, random_sample()};
                send_record(rec);
                items += len;
                records++;
            end
        end
    endtask

    initial begin : result_ready_gen
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (result_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        demod_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: I %0d Q %0d N %0d",
                             m_in_phase, m_quadrature, m_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_in_phase !== want.in_phase || m_quadrature !== want.quadrature ||
                    m_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected I %0d Q %0d N %0d, got I %0d Q %0d N %0d",
                                 want.in_phase, want.quadrature, want.count,
                                 m_in_phase, m_quadrature, m_count);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #60_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_sample  <= '0;
        s_last    <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        for (int k = 0; k <= ROM_Q; k++) begin
            sin_quarter[k] = quarter_sine_entry(k);
        end
        step_word         = '0;
        start_phase       = '0;
        nco_phase         = '0;
        gain_q88          = SCALE_RESET;
        samples_in_record = 0;
        i_accum           = 0;
        q_accum           = 0;
        mismatches        = 0;
        sample_gaps       = 1'b1;
        result_stalls     = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_settings();
        test_register_extremes();
        test_random_records();
        wait_idle();

        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
